>>> rtl/core/spmv_pkg.sv
// Shared constants, command codes and pipeline stage type for the sparse matrix-vector unit.
`default_nettype none

package spmv_pkg;

  localparam int VECTOR_DEPTH_DEF = 1024;
  localparam int VALUE_WIDTH_DEF  = 16;
  localparam int ACC_WIDTH_DEF    = 48;
  localparam int INDEX_WIDTH      = 10;
  localparam int ROW_WIDTH        = 16;
  localparam int CMD_WIDTH        = 2;
  localparam int QUEUE_DEPTH      = 4;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_ACC     = 2'd1,
    CMD_ACC_END = 2'd2,
    CMD_END     = 2'd3
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } stage_t;

endpackage

`default_nettype wire

>>> rtl/core/spmv_if.sv
// Handshake interfaces for the input word and result word channels.
`default_nettype none

interface spmv_in_if #(
  parameter int VALUE_WIDTH = spmv_pkg::VALUE_WIDTH_DEF
) ();
  logic                                 valid;
  logic                                 ready;
  logic [spmv_pkg::CMD_WIDTH-1:0]       command;
  logic [spmv_pkg::INDEX_WIDTH-1:0]     index;
  logic signed [VALUE_WIDTH-1:0]        value;

  modport source (output valid, command, index, value, input ready);
  modport sink (input valid, command, index, value, output ready);
endinterface

interface spmv_out_if #(
  parameter int ACC_WIDTH = spmv_pkg::ACC_WIDTH_DEF
) ();
  logic                             valid;
  logic                             ready;
  logic [spmv_pkg::ROW_WIDTH-1:0]   row_index;
  logic signed [ACC_WIDTH-1:0]      row_sum;
  logic                             last_row;
  logic                             saturated;

  modport source (output valid, row_index, row_sum, last_row, saturated, input ready);
  modport sink (input valid, row_index, row_sum, last_row, saturated, output ready);
endinterface

`default_nettype wire

>>> rtl/core/spmv_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module spmv_ram #(
  parameter int WIDTH = spmv_pkg::VALUE_WIDTH_DEF,
  parameter int DEPTH = spmv_pkg::VECTOR_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/spmv_mac.sv
// Registered multiplier and saturating row accumulator with the row counter.
`default_nettype none

module spmv_mac #(
  parameter int VALUE_WIDTH = spmv_pkg::VALUE_WIDTH_DEF,
  parameter int ACC_WIDTH   = spmv_pkg::ACC_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  spmv_pkg::stage_t                  s1,
  input  logic signed [VALUE_WIDTH-1:0]     nz_value,
  input  logic signed [VALUE_WIDTH-1:0]     vec_value,
  input  logic [spmv_pkg::ROW_WIDTH-1:0]    row_count,
  output logic                              busy,
  output logic                              res_valid,
  output logic [spmv_pkg::ROW_WIDTH-1:0]    res_row_index,
  output logic signed [ACC_WIDTH-1:0]       res_row_sum,
  output logic                              res_last,
  output logic                              res_sat
);

  localparam int RW = spmv_pkg::ROW_WIDTH;
  localparam int PW = 2 * VALUE_WIDTH;
  localparam int SW = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX_A = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN_A = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [SW-1:0]        ACC_MAX_S = SW'(ACC_MAX_A);
  localparam logic signed [SW-1:0]        ACC_MIN_S = SW'(ACC_MIN_A);
  localparam logic [RW-1:0]               ROW_ONE   = 1;

  spmv_pkg::stage_t             s2;
  logic signed [PW-1:0]         prod;
  logic signed [ACC_WIDTH-1:0]  acc;
  logic signed [ACC_WIDTH-1:0]  acc_next;
  logic signed [ACC_WIDTH-1:0]  acc_add;
  logic                         sat_seen;
  logic                         sat_next;
  logic [RW-1:0]                row_ctr;
  logic [RW-1:0]                row_ctr_next;
  logic [RW-1:0]                row_adv;
  logic signed [SW-1:0]         sum;
  logic                         hi;
  logic                         lo;
  logic                         last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s1.valid;
    end
    s2.cmd <= s1.cmd;
    prod   <= nz_value * vec_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      sat_seen <= 1'b0;
      row_ctr  <= '0;
    end else begin
      acc      <= acc_next;
      sat_seen <= sat_next;
      row_ctr  <= row_ctr_next;
    end
  end

  assign sum     = SW'(acc) + SW'(prod);
  assign hi      = sum > ACC_MAX_S;
  assign lo      = sum < ACC_MIN_S;
  assign acc_add = hi ? ACC_MAX_A : (lo ? ACC_MIN_A : ACC_WIDTH'(sum));
  assign last    = row_ctr == (row_count - ROW_ONE);
  assign row_adv = last ? '0 : (row_ctr + ROW_ONE);

  always_comb begin
    acc_next     = acc;
    sat_next     = sat_seen;
    row_ctr_next = row_ctr;
    res_valid    = 1'b0;
    res_row_sum  = acc;
    res_sat      = sat_seen;
    if (s2.valid) begin
      case (s2.cmd)
        spmv_pkg::CMD_WRITE: begin
          acc_next     = '0;
          sat_next     = 1'b0;
          row_ctr_next = '0;
        end
        spmv_pkg::CMD_ACC: begin
          acc_next = acc_add;
          sat_next = sat_seen | hi | lo;
        end
        spmv_pkg::CMD_ACC_END: begin
          res_valid    = 1'b1;
          res_row_sum  = acc_add;
          res_sat      = sat_seen | hi | lo;
          acc_next     = '0;
          sat_next     = 1'b0;
          row_ctr_next = row_adv;
        end
        spmv_pkg::CMD_END: begin
          res_valid    = 1'b1;
          acc_next     = '0;
          sat_next     = 1'b0;
          row_ctr_next = row_adv;
        end
        default: begin
          acc_next = acc;
        end
      endcase
    end
  end

  assign busy          = s2.valid;
  assign res_row_index = row_ctr;
  assign res_last      = last;

endmodule

`default_nettype wire

>>> rtl/core/spmv_outq.sv
// Small register queue that holds finished result words until they are taken.
`default_nettype none

module spmv_outq #(
  parameter int WIDTH = spmv_pkg::ROW_WIDTH,
  parameter int DEPTH = spmv_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       valid,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTRW = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam logic [PTRW-1:0] LAST_SLOT = PTRW'(DEPTH - 1);
  localparam logic [PTRW-1:0] PTR_ONE   = 1;
  localparam logic [CW-1:0]   CNT_ONE   = 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : (wr_ptr + PTR_ONE);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : (rd_ptr + PTR_ONE);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_ONE;
        2'b01:   count <= count - CNT_ONE;
        default: count <= count;
      endcase
    end
  end

  assign dout  = mem[rd_ptr];
  assign valid = count != '0;

endmodule

`default_nettype wire

>>> rtl/core/csr_sparse_matrix_vector_multiply.sv
// Top level of the CSR sparse matrix times dense vector unit.
//
// Channel  Direction  Payload                                      Handshake
// items    in         command, index, value                        valid / ready
// sums     out        row_index, row_sum, last_row, saturated      valid / ready
// cfg      in         cfg_wr_data (row_count)                      cfg_wr_en
//
// One input word is taken per cycle while items.ready is high; each word passes the vector
// RAM read, the registered product and the saturating accumulator, so a row result enters
// the queue from the s2 stage and can then be taken. Reset clears the pipeline, the result
// queue, the accumulator, the saturation flag, the row counter and sets row_count to one;
// the vector RAM keeps its contents.
// items.ready falls only when the four-entry result queue could not hold every word in flight.
`default_nettype none

module csr_sparse_matrix_vector_multiply #(
  parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEF,
  parameter int VALUE_WIDTH  = spmv_pkg::VALUE_WIDTH_DEF,
  parameter int ACC_WIDTH    = spmv_pkg::ACC_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [spmv_pkg::ROW_WIDTH-1:0] cfg_wr_data,
  spmv_in_if.sink                        items,
  spmv_out_if.source                     sums
);

  localparam int AW = $clog2(VECTOR_DEPTH);
  localparam int RW = spmv_pkg::ROW_WIDTH;
  localparam int QW = RW + ACC_WIDTH + 2;
  localparam int QD = spmv_pkg::QUEUE_DEPTH;
  localparam int CW = $clog2(QD + 1);
  localparam logic [RW-1:0] ROW_COUNT_RST = 1;

  logic [RW-1:0]                row_count;
  spmv_pkg::cmd_t               in_cmd;
  logic                         accept;
  logic                         in_range;
  logic [AW-1:0]                addr;
  logic                         ram_we;
  logic [VALUE_WIDTH-1:0]       ram_rdata;
  spmv_pkg::stage_t             s1;
  logic signed [VALUE_WIDTH-1:0] s1_value;
  logic                         s1_in_range;
  logic signed [VALUE_WIDTH-1:0] vec_op;
  logic                         mac_busy;
  logic                         res_valid;
  logic [RW-1:0]                res_row_index;
  logic signed [ACC_WIDTH-1:0]  res_row_sum;
  logic                         res_last;
  logic                         res_sat;
  logic [QW-1:0]                q_din;
  logic [QW-1:0]                q_dout;
  logic [CW-1:0]                q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_COUNT_RST;
    end else if (cfg_wr_en) begin
      row_count <= cfg_wr_data;
    end
  end

  assign in_cmd   = spmv_pkg::cmd_t'(items.command);
  assign accept   = items.valid && items.ready;
  assign in_range = 32'(items.index) < 32'(VECTOR_DEPTH);
  assign addr     = AW'(items.index);
  assign ram_we   = accept && (in_cmd == spmv_pkg::CMD_WRITE) && in_range;

  spmv_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (items.value),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= accept;
    end
    s1.cmd      <= in_cmd;
    s1_value    <= items.value;
    s1_in_range <= in_range;
  end

  assign vec_op = s1_in_range ? $signed(ram_rdata) : '0;

  spmv_mac #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_mac (
    .clk           (clk),
    .rst           (rst),
    .s1            (s1),
    .nz_value      (s1_value),
    .vec_value     (vec_op),
    .row_count     (row_count),
    .busy          (mac_busy),
    .res_valid     (res_valid),
    .res_row_index (res_row_index),
    .res_row_sum   (res_row_sum),
    .res_last      (res_last),
    .res_sat       (res_sat)
  );

  assign q_din = {res_row_index, res_row_sum, res_last, res_sat};

  spmv_outq #(
    .WIDTH (QW),
    .DEPTH (QD)
  ) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .din   (q_din),
    .pop   (sums.valid && sums.ready),
    .dout  (q_dout),
    .valid (sums.valid),
    .count (q_count)
  );

  assign items.ready    = (32'(q_count) + 32'(s1.valid) + 32'(mac_busy)) < QD;
  assign sums.row_index = q_dout[QW-1 -: RW];
  assign sums.row_sum   = $signed(q_dout[2 +: ACC_WIDTH]);
  assign sums.last_row  = q_dout[1];
  assign sums.saturated = q_dout[0];

endmodule

`default_nettype wire

>>> rtl/core/spmv_checker.sv
// Port-level checker for the sparse matrix-vector unit and its bind to the top level.
`default_nettype none

module spmv_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           items_valid,
  input logic                           items_ready,
  input logic [spmv_pkg::CMD_WIDTH-1:0] items_command,
  input logic                           sums_valid,
  input logic                           sums_ready,
  input logic [spmv_pkg::ROW_WIDTH-1:0] sums_row_index,
  input logic                           sums_last_row
);

  localparam logic [spmv_pkg::ROW_WIDTH-1:0] ROW_ONE = 1;

  logic                           prev_last;
  logic [spmv_pkg::ROW_WIDTH-1:0] prev_index;
  logic                           in_end;

  assign in_end = items_valid && items_ready &&
                  ((items_command == spmv_pkg::CMD_ACC_END) ||
                   (items_command == spmv_pkg::CMD_END));

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_last  <= 1'b1;
      prev_index <= '0;
    end else if (sums_valid && sums_ready) begin
      prev_last  <= sums_last_row;
      prev_index <= sums_row_index;
    end
  end

  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    sums_valid && !sums_ready |=> sums_valid)
    else $error("result word withdrawn before it was taken");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !sums_valid)
    else $error("result word present straight after reset");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(sums_valid) |-> $past(in_end, 3))
    else $error("result word appeared without a row-ending input word");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    sums_valid && sums_ready |->
      (sums_row_index == '0) || (!prev_last && (sums_row_index == prev_index + ROW_ONE)))
    else $error("row index out of sequence");

endmodule

bind csr_sparse_matrix_vector_multiply spmv_checker u_spmv_checker (
  .clk            (clk),
  .rst            (rst),
  .items_valid    (items.valid),
  .items_ready    (items.ready),
  .items_command  (items.command),
  .sums_valid     (sums.valid),
  .sums_ready     (sums.ready),
  .sums_row_index (sums.row_index),
  .sums_last_row  (sums.last_row)
);

`default_nettype wire
